// ===== src/ftt_pkg.sv =====
package ftt_pkg;

   localparam int FLOW_ENTRIES_DEF = 64;

   localparam logic [1:0] KIND_PROGRESS = 2'd1;
   localparam logic [1:0] KIND_FIN      = 2'd2;

   localparam logic [7:0] TYPE_NONE = 8'd0;
   localparam logic [7:0] TYPE_MISC = 8'd1;

   localparam logic [31:0] STAMP_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] src_ip;
      logic [15:0] src_port;
      logic [31:0] dst_ip;
      logic [15:0] dst_port;
      logic [7:0]  data_type_in;
      logic [3:0]  encode_type_in;
      logic [3:0]  compress_type_in;
      logic [31:0] now_seconds;
   } req_data_type;

   typedef struct packed {
      logic [31:0] sequence_stamp;
      logic [7:0]  data_type_out;
      logic [3:0]  encode_type_out;
      logic [3:0]  compress_type_out;
      logic        table_full;
   } rsp_data_type;

   typedef struct packed {
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] src_port;
      logic [15:0] dst_port;
   } key_type;

   typedef struct packed {
      logic [31:0] stamp;
      logic [7:0]  dtype;
      logic [3:0]  etype;
      logic [3:0]  ctype;
   } rec_type;

endpackage

// ===== src/ftt_stamp.sv =====
module ftt_stamp (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic [31:0] now_seconds,
   output logic [31:0] fresh_stamp
);

   logic [31:0] last_stamp_ff;
   logic [31:0] last_stamp_in;

   always_comb begin
      if (now_seconds > last_stamp_ff) begin
         fresh_stamp = now_seconds;
      end else if (last_stamp_ff == ftt_pkg::STAMP_MAX) begin
         fresh_stamp = ftt_pkg::STAMP_MAX;
      end else begin
         fresh_stamp = last_stamp_ff + 32'd1;
      end
      last_stamp_in = advance ? fresh_stamp : last_stamp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_stamp_ff <= '0;
      end else begin
         last_stamp_ff <= last_stamp_in;
      end
   end

endmodule

// ===== src/ftt_cam.sv =====
module ftt_cam #(
   parameter int FLOW_ENTRIES = ftt_pkg::FLOW_ENTRIES_DEF,
   localparam int IDX_W = $clog2(FLOW_ENTRIES)
) (
   input  logic                clock,
   input  logic                reset,
   input  ftt_pkg::key_type    key,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_idx,
   input  logic                clr_en,
   input  logic [IDX_W-1:0]    clr_idx,
   output logic                hit,
   output logic [IDX_W-1:0]    hit_idx,
   output logic                free_found,
   output logic [IDX_W-1:0]    free_idx
);

   logic [FLOW_ENTRIES-1:0] valid_ff;
   logic [FLOW_ENTRIES-1:0] valid_in;
   ftt_pkg::key_type        keys_ff [FLOW_ENTRIES];
   logic [FLOW_ENTRIES-1:0] match;

   // index of the matching entry (OR of all matches); duplicates never arise since inserts happen only on a miss
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = 0; i < FLOW_ENTRIES; i++) begin
         match[i] = valid_ff[i] && (keys_ff[i] == key);
         if (match[i]) begin
            hit     = 1'b1;
            hit_idx = hit_idx | IDX_W'(i);
         end
      end
   end

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = FLOW_ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
      if (clr_en) begin
         valid_in[clr_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         keys_ff[wr_idx] <= key;
      end
   end

endmodule

// ===== src/ftt_rec_mem.sv =====
module ftt_rec_mem #(
   parameter int FLOW_ENTRIES = ftt_pkg::FLOW_ENTRIES_DEF,
   localparam int IDX_W = $clog2(FLOW_ENTRIES)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  ftt_pkg::rec_type wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_idx,
   output ftt_pkg::rec_type rd_data
);

   ftt_pkg::rec_type mem [FLOW_ENTRIES];
   ftt_pkg::rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/flow_tag_table_core.sv =====
// A req transfer is registered in stage one and moves on to stage two, whose
// valid is rsp_valid. Throughput: one transfer per cycle unless rsp_stall
// holds stage two. Stage one holds the CAM compare, lowest-free-entry search,
// stamp update and registered record read; stage two selects the response.
// Reset: clears all entry valid bits, the last stamp and pipeline valids;
// the key and record stores are not cleared.
module flow_tag_table_core #(
   parameter int FLOW_ENTRIES = ftt_pkg::FLOW_ENTRIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ftt_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ftt_pkg::rsp_data_type rsp_data
);

   localparam int IDX_W = $clog2(FLOW_ENTRIES);

   logic                  a_valid_ff;
   logic                  a_valid_in;
   ftt_pkg::req_data_type a_data_ff;
   logic                  b_valid_ff;
   logic                  b_valid_in;
   logic                  b_use_stored_ff;
   ftt_pkg::rsp_data_type b_data_ff;

   logic             req_accept;
   logic             advance_b;
   logic             a_fire;
   ftt_pkg::key_type key;
   logic             hit;
   logic [IDX_W-1:0] hit_idx;
   logic             free_found;
   logic [IDX_W-1:0] free_idx;
   logic [31:0]      fresh_stamp;
   logic             is_prog;
   logic             is_fin;
   logic             dnone;
   logic             use_stored;
   logic             rec_write;
   logic [IDX_W-1:0] slot;
   logic             full;
   logic [7:0]       dtype_res;
   ftt_pkg::rec_type wr_rec;
   ftt_pkg::rec_type rd_rec;

   assign advance_b  = !b_valid_ff || !rsp_stall;
   assign a_fire     = a_valid_ff && advance_b;
   assign req_stall  = a_valid_ff && !advance_b;
   assign req_accept = req_valid && !req_stall;

   assign key.src_ip   = a_data_ff.src_ip;
   assign key.dst_ip   = a_data_ff.dst_ip;
   assign key.src_port = a_data_ff.src_port;
   assign key.dst_port = a_data_ff.dst_port;

   always_comb begin
      is_prog    = a_data_ff.req_type == ftt_pkg::KIND_PROGRESS;
      is_fin     = a_data_ff.req_type == ftt_pkg::KIND_FIN;
      dnone      = a_data_ff.data_type_in == ftt_pkg::TYPE_NONE;
      use_stored = hit && ((is_prog && dnone) || is_fin);
      rec_write  = is_prog && !use_stored && (hit || free_found);
      full       = is_prog && !use_stored && !hit && !free_found;
      slot       = hit ? hit_idx : free_idx;
      if (is_fin || (is_prog && !hit && dnone)) begin
         dtype_res = ftt_pkg::TYPE_MISC;
      end else begin
         dtype_res = a_data_ff.data_type_in;
      end
      wr_rec.stamp = fresh_stamp;
      wr_rec.dtype = dtype_res;
      wr_rec.etype = a_data_ff.encode_type_in;
      wr_rec.ctype = a_data_ff.compress_type_in;
   end

   ftt_stamp u_stamp (
      .clock       (clock),
      .reset       (reset),
      .advance     (a_fire && !use_stored),
      .now_seconds (a_data_ff.now_seconds),
      .fresh_stamp (fresh_stamp)
   );

   ftt_cam #(
      .FLOW_ENTRIES (FLOW_ENTRIES)
   ) u_cam (
      .clock      (clock),
      .reset      (reset),
      .key        (key),
      .wr_en      (a_fire && rec_write),
      .wr_idx     (slot),
      .clr_en     (a_fire && is_fin && hit),
      .clr_idx    (hit_idx),
      .hit        (hit),
      .hit_idx    (hit_idx),
      .free_found (free_found),
      .free_idx   (free_idx)
   );

   ftt_rec_mem #(
      .FLOW_ENTRIES (FLOW_ENTRIES)
   ) u_rec_mem (
      .clock   (clock),
      .wr_en   (a_fire && rec_write),
      .wr_idx  (slot),
      .wr_data (wr_rec),
      .rd_en   (a_fire),
      .rd_idx  (hit_idx),
      .rd_data (rd_rec)
   );

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_accept) begin
         a_valid_in = 1'b1;
      end else if (a_fire) begin
         a_valid_in = 1'b0;
      end
      b_valid_in = b_valid_ff;
      if (a_fire) begin
         b_valid_in = 1'b1;
      end else if (b_valid_ff && !rsp_stall) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_data_ff <= req_data;
      end
      if (a_fire) begin
         b_use_stored_ff             <= use_stored;
         b_data_ff.sequence_stamp    <= fresh_stamp;
         b_data_ff.data_type_out     <= dtype_res;
         b_data_ff.encode_type_out   <= a_data_ff.encode_type_in;
         b_data_ff.compress_type_out <= a_data_ff.compress_type_in;
         b_data_ff.table_full        <= full;
      end
   end

   // stored record comes straight from the memory read register
   always_comb begin
      rsp_data = b_data_ff;
      if (b_use_stored_ff) begin
         rsp_data.sequence_stamp    = rd_rec.stamp;
         rsp_data.data_type_out     = rd_rec.dtype;
         rsp_data.encode_type_out   = rd_rec.etype;
         rsp_data.compress_type_out = rd_rec.ctype;
         rsp_data.table_full        = 1'b0;
      end
   end

   assign rsp_valid = b_valid_ff;

endmodule

// ===== bench/flow_tag_table_core_tb.sv =====
`timescale 1ns / 1ps

module flow_tag_table_core_tb;

   localparam int FLOW_ENTRIES = ftt_pkg::FLOW_ENTRIES_DEF;
   localparam logic [1:0] KIND_UNTRACKED = 2'd0;
   localparam logic [1:0] KIND_SPARE     = 2'd3;
   localparam int KEY_POOL = 96;
   localparam int RANDOM_ITEMS = 1560;
   localparam int PHASE_LEN = 200;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 300000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   ftt_pkg::req_data_type req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   ftt_pkg::rsp_data_type rsp_data;

   flow_tag_table_core #(.FLOW_ENTRIES(FLOW_ENTRIES)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // flow table shadow
   bit                    flow_used [FLOW_ENTRIES];
   ftt_pkg::key_type      flow_key [FLOW_ENTRIES];
   ftt_pkg::rec_type      flow_rec [FLOW_ENTRIES];
   logic [31:0]           last_stamp = '0;

   ftt_pkg::req_data_type waiting_packets [$];
   bit                    drain_before [$];
   ftt_pkg::rsp_data_type due_tags [$];

   ftt_pkg::key_type      key_pool [KEY_POOL];
   int                    accepted_cnt = 0;
   int                    planned_cnt = 0;
   int                    mismatches = 0;
   int                    cycles = 0;
   bit                    req_taken = 1'b0;
   bit                    rsp_taken = 1'b0;
   int                    send_gap = 0;
   bit                    send_burst = 1'b0;
   int                    recv_wait = 0;
   bit                    recv_burst = 1'b0;
   int                    hold_left = 0;
   int                    holds_done = 0;

   function automatic logic [31:0] next_stamp(input logic [31:0] now);
      if (now > last_stamp) begin
         last_stamp = now;
      end else if (last_stamp != ftt_pkg::STAMP_MAX) begin
         last_stamp = last_stamp + 32'd1;
      end
      return last_stamp;
   endfunction

   function automatic ftt_pkg::rsp_data_type tag_packet(input ftt_pkg::req_data_type r);
      ftt_pkg::rsp_data_type o;
      ftt_pkg::key_type      k;
      int                    hit;
      int                    slot;
      k.src_ip = r.src_ip;
      k.dst_ip = r.dst_ip;
      k.src_port = r.src_port;
      k.dst_port = r.dst_port;
      o.sequence_stamp = '0;
      o.data_type_out = r.data_type_in;
      o.encode_type_out = r.encode_type_in;
      o.compress_type_out = r.compress_type_in;
      o.table_full = 1'b0;
      hit = -1;
      for (int i = 0; i < FLOW_ENTRIES; i++)
         if (hit < 0 && flow_used[i] && flow_key[i] == k) hit = i;
      if ((r.req_type == ftt_pkg::KIND_PROGRESS && hit >= 0
           && r.data_type_in == ftt_pkg::TYPE_NONE)
          || (r.req_type == ftt_pkg::KIND_FIN && hit >= 0)) begin
         o.sequence_stamp = flow_rec[hit].stamp;
         o.data_type_out = flow_rec[hit].dtype;
         o.encode_type_out = flow_rec[hit].etype;
         o.compress_type_out = flow_rec[hit].ctype;
         if (r.req_type == ftt_pkg::KIND_FIN) flow_used[hit] = 1'b0;
      end else if (r.req_type == ftt_pkg::KIND_PROGRESS) begin
         o.sequence_stamp = next_stamp(r.now_seconds);
         if (hit < 0 && r.data_type_in == ftt_pkg::TYPE_NONE)
            o.data_type_out = ftt_pkg::TYPE_MISC;
         slot = hit;
         for (int i = 0; i < FLOW_ENTRIES; i++)
            if (slot < 0 && !flow_used[i]) slot = i;
         if (slot < 0) begin
            o.table_full = 1'b1;
         end else begin
            flow_used[slot] = 1'b1;
            flow_key[slot] = k;
            flow_rec[slot].stamp = o.sequence_stamp;
            flow_rec[slot].dtype = o.data_type_out;
            flow_rec[slot].etype = o.encode_type_out;
            flow_rec[slot].ctype = o.compress_type_out;
         end
      end else if (r.req_type == ftt_pkg::KIND_FIN) begin
         o.sequence_stamp = next_stamp(r.now_seconds);
         o.data_type_out = ftt_pkg::TYPE_MISC;
      end else begin
         o.sequence_stamp = next_stamp(r.now_seconds);
      end
      return o;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %h, actual %h", name, want, got);
      end
   endtask

   function automatic ftt_pkg::key_type random_key();
      ftt_pkg::key_type k;
      k.src_ip = $urandom;
      k.dst_ip = $urandom;
      k.src_port = 16'($urandom_range(0, 65535));
      k.dst_port = 16'($urandom_range(0, 65535));
      return k;
   endfunction

   task automatic queue_packet(input logic [1:0] kind, input ftt_pkg::key_type k,
                               input logic [7:0] d, input logic [3:0] e,
                               input logic [3:0] c, input logic [31:0] now,
                               input bit drain);
      ftt_pkg::req_data_type r;
      r.req_type = kind;
      r.src_ip = k.src_ip;
      r.dst_ip = k.dst_ip;
      r.src_port = k.src_port;
      r.dst_port = k.dst_port;
      r.data_type_in = d;
      r.encode_type_in = e;
      r.compress_type_in = c;
      r.now_seconds = now;
      waiting_packets.push_back(r);
      drain_before.push_back(drain);
   endtask

   // sender
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (waiting_packets.size() != 0
                      && !(drain_before[0] && due_tags.size() != 0)) begin
            req_valid <= 1'b1;
            req_data <= waiting_packets.pop_front();
            void'(drain_before.pop_front());
            send_gap <= send_burst ? 0 : int'($urandom_range(0, 16));
            if ($urandom_range(0, 31) == 0) send_burst <= !send_burst;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin : rx_drive
      int n;
      n = rsp_taken ? (recv_burst ? 0 : int'($urandom_range(0, 16))) : recv_wait;
      if (rsp_taken && $urandom_range(0, 31) == 0) recv_burst <= !recv_burst;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         recv_wait <= n;
      end else if (n != 0) begin
         rsp_stall <= 1'b1;
         recv_wait <= n - 1;
      end else begin
         rsp_stall <= 1'b0;
         recv_wait <= 0;
      end
   end

   // long receiver hold-off so the pipeline backs up into req_stall
   always @(negedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (holds_done < 2
                   && accepted_cnt >= (holds_done == 0 ? 300 : 1100)) begin
         hold_left <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
      end
   end

   // transfer monitor
   always @(posedge clock) begin : xfer_mon
      ftt_pkg::rsp_data_type want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         rsp_taken <= rsp_valid && !rsp_stall;
         if (rsp_valid && !rsp_stall) begin
            if (due_tags.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected rsp transfer: %h", rsp_data);
            end else begin
               want = due_tags.pop_front();
               check_field("sequence_stamp", want.sequence_stamp, rsp_data.sequence_stamp);
               check_field("data_type_out", 32'(want.data_type_out),
                           32'(rsp_data.data_type_out));
               check_field("encode_type_out", 32'(want.encode_type_out),
                           32'(rsp_data.encode_type_out));
               check_field("compress_type_out", 32'(want.compress_type_out),
                           32'(rsp_data.compress_type_out));
               check_field("table_full", 32'(want.table_full), 32'(rsp_data.table_full));
            end
         end
         if (req_valid && !req_stall) begin
            due_tags.push_back(tag_packet(req_data));
            accepted_cnt <= accepted_cnt + 1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      ftt_pkg::key_type ka;
      ftt_pkg::key_type kp;
      ftt_pkg::key_type ki;
      ftt_pkg::key_type k0;
      ftt_pkg::key_type k1;
      ftt_pkg::key_type k;
      logic [1:0]       kind;
      logic [7:0]       d;
      logic [31:0]      time_base;
      logic [31:0]      now;
      int               r;
      bit               fill;

      for (int i = 0; i < KEY_POOL; i++) key_pool[i] = random_key();
      ka = key_pool[0];
      kp = ka;
      kp.src_port = ka.dst_port;
      kp.dst_port = ka.src_port;
      ki = ka;
      ki.src_ip = ka.dst_ip;
      ki.dst_ip = ka.src_ip;
      k0 = '0;
      k1 = '1;
      key_pool[1] = kp;
      key_pool[2] = ki;
      key_pool[3] = k1;
      key_pool[4] = k0;

      // directed
      queue_packet(KIND_UNTRACKED, k0, 8'h00, 4'h0, 4'h0, 32'd0, 1'b0);
      queue_packet(KIND_UNTRACKED, k1, 8'hFF, 4'hF, 4'hF, 32'd100, 1'b0);
      queue_packet(KIND_SPARE, k1, 8'hFF, 4'hF, 4'hF, 32'd5, 1'b0);
      queue_packet(ftt_pkg::KIND_PROGRESS, ka, ftt_pkg::TYPE_NONE, 4'h3, 4'h2, 32'd200, 1'b0);
      queue_packet(ftt_pkg::KIND_PROGRESS, ka, ftt_pkg::TYPE_NONE, 4'hF, 4'hF, 32'd201, 1'b0);
      queue_packet(ftt_pkg::KIND_PROGRESS, ka, 8'h80, 4'hF, 4'h5, 32'd150, 1'b0);
      queue_packet(ftt_pkg::KIND_PROGRESS, ka, ftt_pkg::TYPE_NONE, 4'h0, 4'h0, 32'd300, 1'b0);
      queue_packet(ftt_pkg::KIND_PROGRESS, kp, ftt_pkg::TYPE_NONE, 4'h1, 4'h1, 32'd301, 1'b0);
      queue_packet(ftt_pkg::KIND_PROGRESS, ki, 8'h07, 4'h0, 4'h0, 32'd302, 1'b0);
      queue_packet(ftt_pkg::KIND_FIN, ka, 8'h09, 4'h0, 4'h0, 32'd400, 1'b0);
      queue_packet(ftt_pkg::KIND_FIN, ka, ftt_pkg::TYPE_NONE, 4'h6, 4'h7, 32'd401, 1'b0);
      queue_packet(ftt_pkg::KIND_PROGRESS, ka, ftt_pkg::TYPE_NONE, 4'h2, 4'h9, 32'd402, 1'b0);
      queue_packet(ftt_pkg::KIND_FIN, k1, 8'hFF, 4'hF, 4'hF, 32'd403, 1'b0);
      queue_packet(ftt_pkg::KIND_PROGRESS, k1, 8'hFF, 4'hF, 4'hF, 32'd404, 1'b0);
      queue_packet(ftt_pkg::KIND_PROGRESS, k1, ftt_pkg::TYPE_NONE, 4'h0, 4'h0, 32'd405, 1'b0);
      queue_packet(ftt_pkg::KIND_FIN, k1, ftt_pkg::TYPE_NONE, 4'h0, 4'h0, 32'd406, 1'b0);
      queue_packet(ftt_pkg::KIND_PROGRESS, k0, ftt_pkg::TYPE_NONE, 4'h0, 4'h0, 32'd0, 1'b0);
      queue_packet(ftt_pkg::KIND_FIN, k0, ftt_pkg::TYPE_NONE, 4'h0, 4'h0, 32'd0, 1'b0);
      queue_packet(ftt_pkg::KIND_FIN, kp, ftt_pkg::TYPE_NONE, 4'h0, 4'h0, 32'd500, 1'b0);
      queue_packet(ftt_pkg::KIND_FIN, ki, ftt_pkg::TYPE_NONE, 4'h0, 4'h0, 32'd501, 1'b0);
      queue_packet(ftt_pkg::KIND_FIN, ka, ftt_pkg::TYPE_NONE, 4'h0, 4'h0, 32'd502, 1'b0);

      // random: alternating fill-heavy and release-heavy phases
      time_base = 32'd1000;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         fill = ((n / PHASE_LEN) % 2) == 0;
         r = $urandom_range(0, 99);
         if (fill)
            kind = r < 70 ? ftt_pkg::KIND_PROGRESS : r < 80 ? ftt_pkg::KIND_FIN
                 : r < 95 ? KIND_UNTRACKED : KIND_SPARE;
         else
            kind = r < 15 ? ftt_pkg::KIND_PROGRESS : r < 65 ? ftt_pkg::KIND_FIN
                 : r < 90 ? KIND_UNTRACKED : KIND_SPARE;
         k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, KEY_POOL - 1)]
                                          : random_key();
         d = $urandom_range(0, 1) ? ftt_pkg::TYPE_NONE : 8'($urandom_range(0, 255));
         time_base = time_base + $urandom_range(0, 3);
         now = time_base - $urandom_range(0, 2);
         queue_packet(kind, k, d, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                      now, n % PHASE_LEN == 0);
      end

      // high time bits, then stamp saturation
      queue_packet(KIND_UNTRACKED, random_key(), 8'h12, 4'h3, 4'h4, 32'hAAAA_AAAA, 1'b1);
      queue_packet(KIND_UNTRACKED, random_key(), 8'h21, 4'h4, 4'h3, 32'h5555_5555, 1'b0);
      queue_packet(ftt_pkg::KIND_PROGRESS, key_pool[5], ftt_pkg::TYPE_NONE, 4'h5, 4'h6,
                   32'hFFFF_FFFE, 1'b0);
      queue_packet(KIND_UNTRACKED, random_key(), 8'h00, 4'h0, 4'h0, ftt_pkg::STAMP_MAX,
                   1'b0);
      queue_packet(KIND_UNTRACKED, random_key(), 8'h00, 4'h0, 4'h0, 32'd0, 1'b0);
      queue_packet(ftt_pkg::KIND_PROGRESS, key_pool[5], ftt_pkg::TYPE_NONE, 4'h0, 4'h0,
                   32'd3, 1'b0);
      queue_packet(ftt_pkg::KIND_FIN, key_pool[5], ftt_pkg::TYPE_NONE, 4'h0, 4'h0,
                   ftt_pkg::STAMP_MAX, 1'b0);
      queue_packet(ftt_pkg::KIND_FIN, key_pool[5], ftt_pkg::TYPE_NONE, 4'h0, 4'h0,
                   32'd7, 1'b0);
      for (int n = 0; n < 6; n++)
         queue_packet(2'($urandom_range(0, 3)), key_pool[$urandom_range(0, KEY_POOL - 1)],
                      8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                      4'($urandom_range(0, 15)), $urandom, 1'b0);
      planned_cnt = waiting_packets.size();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (accepted_cnt < planned_cnt || due_tags.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/ftt_pkg.sv
src/ftt_stamp.sv
src/ftt_cam.sv
src/ftt_rec_mem.sv
src/flow_tag_table_core.sv
bench/flow_tag_table_core_tb.sv
